// ----- hw/rtl/smx_pkg.sv -----
`default_nettype none
package smx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int REG_COUNT   = 4;
  localparam int MEM_WORDS   = 128;

  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int RS_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int MA_W = $clog2(MEM_WORDS);

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_POP  = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_OUT  = 4'd6;
  localparam logic [3:0] OP_HLT  = 4'd7;
  localparam logic [3:0] OP_JMP  = 4'd8;
  localparam logic [3:0] OP_JB   = 4'd9;
  localparam logic [3:0] OP_JBE  = 4'd10;
  localparam logic [3:0] OP_JA   = 4'd11;
  localparam logic [3:0] OP_JAE  = 4'd12;

  localparam logic [2:0] K_NUM  = 3'd0;
  localparam logic [2:0] K_REG  = 3'd1;
  localparam logic [2:0] K_RNUM = 3'd2;
  localparam logic [2:0] K_MADR = 3'd3;
  localparam logic [2:0] K_MREG = 3'd4;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_UND  = 3'd1;
  localparam logic [2:0] E_OVF  = 3'd2;
  localparam logic [2:0] E_DZ   = 3'd3;
  localparam logic [2:0] E_ADDR = 3'd4;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [2:0]         arg_kind;
    logic signed [31:0] imm_value;
    logic [1:0]         reg_sel;
    logic [6:0]         mem_addr;
    logic [15:0]        jump_target;
  } smx_instr_t;

  typedef struct packed {
    logic [15:0]        next_ip;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic [2:0]         error_code;
  } smx_result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_RD2, S_RD3, S_EXEC, S_DIV, S_WB, S_WB2
  } smx_state_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic cap_top;
    logic cap_next;
    logic exec;
    logic commit;
    logic commit2;
  } smx_cmd_t;

  typedef struct packed {
    logic do_div;
    logic div_done;
    logic out_busy;
    logic two_push;
  } smx_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/smx_if.sv -----
`default_nettype none
interface smx_in_if;
  import smx_pkg::*;
  logic       valid;
  logic       ready;
  smx_instr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface smx_out_if;
  import smx_pkg::*;
  logic        valid;
  logic        ready;
  smx_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/smx_ram.sv -----
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/smx_div.sv -----
`default_nettype none
module smx_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num_mag,  // magnitude of the Q16.16 dividend, scaled by 2^16 inside
  input  wire logic [31:0] den_mag,
  input  wire logic        neg,
  output logic             done,
  output logic [31:0]      quot
);
  import smx_pkg::*;

  logic [47:0] q;
  logic [31:0] rem;
  logic [31:0] den;
  logic        sgn;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rsh;
  logic [32:0] diff;
  logic [47:0] qn;

  always_comb begin
    rsh  = {rem, q[47]};
    diff = rsh - {1'b0, den};
    qn   = {q[46:0], ~diff[32]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        q    <= {num_mag, 16'd0};
        rem  <= 32'd0;
        den  <= den_mag;
        sgn  <= neg;
      end else if (busy) begin
        q   <= qn;
        rem <= diff[32] ? rsh[31:0] : diff[31:0];
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
          // saturate the signed result
          if (sgn) begin
            quot <= (qn > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-qn);
          end else begin
            quot <= (qn > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : qn[31:0];
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/smx_dp.sv -----
`default_nettype none
module smx_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire smx_pkg::smx_cmd_t cm,
  output smx_pkg::smx_stat_t     st,
  input  wire smx_pkg::smx_instr_t in_data,
  output smx_pkg::smx_result_t   res_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata
);
  import smx_pkg::*;

  smx_instr_t         ins;
  logic [SP_W-1:0]    sp;
  logic [15:0]        ip;
  logic               halt_flag;
  logic [15:0]        plen;
  logic [31:0]        regs [REG_COUNT];
  logic [MEM_WORDS-1:0] mvld;
  logic               mv_q;
  logic [31:0]        top;
  logic [31:0]        nxt;
  logic [31:0]        memval;
  logic signed [63:0] prod;

  logic [31:0]        s_rdata;
  logic [31:0]        m_rdata;
  logic [SA_W-1:0]    s_raddr;
  logic [31:0]        div_q;
  logic               div_done;

  // decode
  logic [RS_W-1:0] r_sel;
  logic [31:0]     reg_val;
  logic [15:0]     reg_hi;
  logic            rs_bad, ra_bad, ma_bad;
  logic [MA_W-1:0] maddr;

  // execution results
  logic [15:0]     nip;
  logic [2:0]      err;
  logic [SP_W-1:0] sp_n;
  logic            swe;
  logic [SA_W-1:0] swa;
  logic [31:0]     swd;
  logic            mwe, rwe, ovalid, hlt, two, halt_path;
  logic [31:0]     alu;
  logic [32:0]     s33;
  logic            cond;

  logic            st_we;
  logic [SA_W-1:0] st_wa;
  logic [31:0]     st_wd;
  logic            m_we;

  always_comb begin
    r_sel   = ins.reg_sel[RS_W-1:0];
    reg_val = regs[r_sel];
    reg_hi  = reg_val[31:16];
    rs_bad  = 32'(ins.reg_sel) >= REG_COUNT;
    ra_bad  = reg_val[31] || (32'(reg_hi) >= MEM_WORDS);
    ma_bad  = 32'(ins.mem_addr) >= MEM_WORDS;
    maddr   = (ins.arg_kind == K_MREG) ? reg_hi[MA_W-1:0] : MA_W'(ins.mem_addr);
    halt_path = halt_flag || (ip >= plen);
  end

  // arithmetic on the two top words
  always_comb begin
    s33 = 33'd0;
    alu = div_q;
    case (ins.cmd)
      OP_ADD, OP_SUB: begin
        s33 = (ins.cmd == OP_ADD) ? ({nxt[31], nxt} + {top[31], top})
                                  : ({nxt[31], nxt} - {top[31], top});
        if (s33[32] != s33[31]) begin
          alu = s33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          alu = s33[31:0];
        end
      end
      OP_MUL: begin
        if (prod[63] && !(&prod[62:47])) begin
          alu = 32'h8000_0000;
        end else if (!prod[63] && (|prod[62:47])) begin
          alu = 32'h7FFF_FFFF;
        end else begin
          alu = prod[47:16];
        end
      end
      default: alu = div_q;
    endcase
    case (ins.cmd)
      OP_JB:   cond = $signed(nxt) <  $signed(top);
      OP_JBE:  cond = $signed(nxt) <= $signed(top);
      OP_JA:   cond = $signed(nxt) >  $signed(top);
      default: cond = $signed(nxt) >= $signed(top);
    endcase
  end

  always_comb begin
    nip    = ip + 16'd1;
    err    = E_NONE;
    sp_n   = sp;
    swe    = 1'b0;
    swa    = sp[SA_W-1:0];
    swd    = ins.imm_value;
    mwe    = 1'b0;
    rwe    = 1'b0;
    ovalid = 1'b0;
    hlt    = 1'b0;
    two    = 1'b0;
    case (ins.cmd)
      OP_PUSH: begin
        nip = (ins.arg_kind == K_RNUM) ? ip + 16'd4 : ip + 16'd3;
        if (ins.arg_kind > K_MREG) begin
          nip = ip + 16'd2;
        end else if ((32'(sp) + ((ins.arg_kind == K_RNUM) ? 32'd2 : 32'd1)) > STACK_DEPTH) begin
          err = E_OVF;
        end else if (ins.arg_kind == K_NUM) begin
          swe = 1'b1;
          sp_n = sp + SP_W'(1);
        end else if (ins.arg_kind == K_MADR) begin
          if (ma_bad) begin
            err = E_ADDR;
          end else begin
            swe = 1'b1; swd = memval; sp_n = sp + SP_W'(1);
          end
        end else if (rs_bad) begin
          err = E_ADDR;
        end else if (ins.arg_kind == K_MREG) begin
          if (ra_bad) begin
            err = E_ADDR;
          end else begin
            swe = 1'b1; swd = memval; sp_n = sp + SP_W'(1);
          end
        end else begin
          swe = 1'b1; swd = reg_val; sp_n = sp + SP_W'(1);
          if (ins.arg_kind == K_RNUM) begin
            two  = 1'b1;
            sp_n = sp + SP_W'(2);
          end
        end
      end
      OP_POP: begin
        nip = ip + 16'd3;
        if (!(ins.arg_kind inside {K_REG, K_MADR, K_MREG})) begin
          nip = ip + 16'd2;
        end else if (sp == '0) begin
          err = E_UND;
        end else if (ins.arg_kind == K_MADR) begin
          if (ma_bad) err = E_ADDR;
          else begin
            mwe = 1'b1; sp_n = sp - SP_W'(1);
          end
        end else if (rs_bad) begin
          err = E_ADDR;
        end else if (ins.arg_kind == K_MREG) begin
          if (ra_bad) err = E_ADDR;
          else begin
            mwe = 1'b1; sp_n = sp - SP_W'(1);
          end
        end else begin
          rwe = 1'b1; sp_n = sp - SP_W'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (sp < SP_W'(2)) begin
          err = E_UND;
        end else if (ins.cmd == OP_DIV && top == 32'd0) begin
          err = E_DZ;
        end else begin
          swe  = 1'b1;
          swa  = SA_W'(sp - SP_W'(2));
          swd  = alu;
          sp_n = sp - SP_W'(1);
        end
      end
      OP_OUT: begin
        if (sp == '0) err = E_UND;
        else begin
          ovalid = 1'b1; sp_n = sp - SP_W'(1);
        end
      end
      OP_HLT: hlt = 1'b1;
      OP_JMP: nip = ins.jump_target;
      OP_JB, OP_JBE, OP_JA, OP_JAE: begin
        nip = ip + 16'd2;
        if (sp < SP_W'(2)) err = E_UND;
        else begin
          sp_n = sp - SP_W'(2);
          if (cond) nip = ins.jump_target;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st.do_div   = (ins.cmd == OP_DIV) && (sp >= SP_W'(2)) && (top != 32'd0) && !halt_path;
    st.div_done = div_done;
    st.out_busy = res_valid && !res_ready;
    st.two_push = two && !halt_path;

    s_raddr = cm.dec ? SA_W'(sp - SP_W'(1)) : SA_W'(sp - SP_W'(2));
    st_we = (cm.commit && swe && !halt_path) || cm.commit2;
    st_wa = cm.commit2 ? SA_W'(sp - SP_W'(1)) : swa;
    st_wd = cm.commit2 ? ins.imm_value : swd;
    m_we  = cm.commit && mwe && !halt_path;
  end

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  smx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(m_we), .waddr(maddr), .wdata(top),
    .raddr(maddr), .rdata(m_rdata)
  );

  smx_div u_div (
    .clk(clk), .rst(rst), .start(cm.exec && st.do_div),
    .num_mag(nxt[31] ? 32'(-nxt) : nxt),
    .den_mag(top[31] ? 32'(-top) : top),
    .neg(nxt[31] ^ top[31]),
    .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (cm.load) ins <= in_data;
    mv_q <= mvld[maddr];
    if (cm.cap_top) begin
      top    <= s_rdata;
      memval <= mv_q ? m_rdata : 32'd0;
    end
    if (cm.cap_next) nxt <= s_rdata;
    if (cm.exec) prod <= $signed(nxt) * $signed(top);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      ip        <= 16'd0;
      halt_flag <= 1'b0;
      plen      <= 16'd0;
      mvld      <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= 32'd0;
    end else begin
      if (cfg_we) plen <= cfg_wdata;
      if (cm.commit) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      if (m_we) mvld[maddr] <= 1'b1;
      if (cm.commit) begin
        if (halt_path) begin
          halt_flag <= 1'b1;
          res_data  <= '{next_ip: ip, out_valid: 1'b0, out_value: 32'sd0,
                         halted: 1'b1, error_code: E_NONE};
        end else begin
          ip        <= nip;
          sp        <= sp_n;
          halt_flag <= hlt || (nip >= plen);
          if (rwe) regs[r_sel] <= top;
          res_data  <= '{next_ip: nip, out_valid: ovalid,
                         out_value: ovalid ? top : 32'd0,
                         halted: hlt || (nip >= plen), error_code: err};
        end
      end
    end
  end

  default clocking @(posedge clk); endclocking
  default disable iff (rst);

  a_sp_range: assert property (32'(sp) <= STACK_DEPTH)
    else $error("stack pointer beyond depth");
  a_halt_sticky: assert property (halt_flag |=> halt_flag)
    else $error("halt flag cleared without reset");
  a_commit_result: assert property (cm.commit |=> res_valid)
    else $error("commit left no result");
  a_no_div_on_fault: assert property (cm.exec && st.do_div |-> top != 32'd0)
    else $error("divider started on zero divisor");
endmodule
`default_nettype wire

// ----- hw/rtl/smx_ctrl.sv -----
`default_nettype none
module smx_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire smx_pkg::smx_stat_t st,
  output smx_pkg::smx_cmd_t       cm
);
  import smx_pkg::*;

  smx_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC:  state_next = S_RD2;
      S_RD2:  state_next = S_RD3;
      S_RD3:  state_next = S_EXEC;
      S_EXEC: state_next = st.do_div ? S_DIV : S_WB;
      S_DIV:  if (st.div_done) state_next = S_WB;
      S_WB:   if (!st.out_busy) state_next = st.two_push ? S_WB2 : S_IDLE;
      S_WB2:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    cm         = '0;
    cm.load    = (state == S_IDLE) && in_valid;
    cm.dec     = (state == S_DEC);
    cm.cap_top = (state == S_RD2);
    cm.cap_next = (state == S_RD3);
    cm.exec    = (state == S_EXEC);
    cm.commit  = (state == S_WB) && !st.out_busy;
    cm.commit2 = (state == S_WB2);
  end
endmodule
`default_nettype wire

// ----- hw/rtl/stack_machine_executor.sv -----
`default_nettype none
// Stack machine executor: takes one decoded instruction word and returns one
// result word (next pointer, output value, halt flag, error code). Operand
// stack of 64 Q16.16 words and 128-word data memory sit in registered-read
// RAMs; four general registers are flops. Each instruction runs through a
// fixed sequence: decode and first stack read, top capture and second read,
// next capture, execute, write back. The register-then-number push takes a
// further write-back step (two stack writes on the single write port), and
// div adds a divide step in which its 48-bit restoring divider resolves one
// quotient bit a cycle. A new word is taken only once the previous one has
// been written back; the result register lets the next word in while the
// last result still waits, but that word then holds in write back until the
// result is taken. Errors are flagged and the instruction is skipped.
// program_length is written through cfg_we/cfg_wdata while idle; a pointer
// at or past it halts the machine until reset.
module stack_machine_executor (
  input  wire logic        clk,
  input  wire logic        rst,
  smx_in_if.sink           in_ch,
  smx_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import smx_pkg::*;

  smx_cmd_t  cm;
  smx_stat_t st;

  // sequencer
  smx_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .cm(cm)
  );

  // stack, registers, memory, ALU and result register
  smx_dp u_dp (
    .clk(clk), .rst(rst), .cm(cm), .st(st),
    .in_data(in_ch.data),
    .res_data(out_ch.data), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );
endmodule
`default_nettype wire

// ----- tb/stack_machine_executor_test.sv -----
`timescale 1ns / 100ps
module stack_machine_executor_test;
  import smx_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  smx_in_if  in_ch ();
  smx_out_if out_ch ();

  stack_machine_executor u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the machine, advanced once per accepted instruction word.
  logic [31:0] m_stack [STACK_DEPTH];
  int unsigned m_sp;
  logic [31:0] m_regs [REG_COUNT];
  logic [31:0] m_mem [MEM_WORDS];
  logic [15:0] m_ip;
  logic        m_halt;
  logic [15:0] m_len;

  smx_result_t expected_words [$];
  int          fail_count;
  int          src_pct;
  int          snk_pct;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --- shadow model helpers -------------------------------------------------
  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint sx(input logic [31:0] v);
    longint r;
    r = longint'($signed(v));
    return r;
  endfunction

  task automatic push_val(input logic [31:0] v);
    m_stack[m_sp] = v;
    m_sp++;
  endtask

  function automatic logic [31:0] pop_val();
    m_sp--;
    return m_stack[m_sp];
  endfunction

  // Register holds a Q16.16 value; its integer part is the memory address.
  function automatic bit reg_to_addr(input logic [1:0] rs, output logic [6:0] a);
    longint v;
    v = sx(m_regs[rs]);
    a = '0;
    if (v < 0) return 1'b0;
    v = v >>> 16;
    if (v >= MEM_WORDS) return 1'b0;
    a = v[6:0];
    return 1'b1;
  endfunction

  function automatic logic [31:0] alu_q16(input logic [3:0] op, input longint nx,
                                          input longint tp);
    longint p;
    case (op)
      OP_ADD: return sat32(nx + tp);
      OP_SUB: return sat32(nx - tp);
      OP_MUL: begin
        p = nx * tp;
        return sat32(p >>> 16); // floor on the product
      end
      default: return sat32((nx * 65536) / tp); // truncates toward zero
    endcase
  endfunction

  task automatic step_machine(input smx_instr_t w, output smx_result_t r);
    logic [16:0] nip;
    logic [6:0]  a;
    longint      tp;
    longint      nx;
    bit          taken;
    r = '0;
    if (m_halt || m_ip >= m_len) begin
      m_halt = 1'b1;
      r.next_ip = m_ip;
      r.halted  = 1'b1;
      return;
    end
    nip = m_ip + 17'd1;
    case (w.cmd)
      OP_PUSH: begin
        nip = m_ip + ((w.arg_kind == K_RNUM) ? 17'd4 : 17'd3);
        if (w.arg_kind > K_MREG) nip = m_ip + 17'd2;
        else if (m_sp + ((w.arg_kind == K_RNUM) ? 2 : 1) > STACK_DEPTH) r.error_code = E_OVF;
        else case (w.arg_kind)
          K_NUM:  push_val(w.imm_value);
          K_MADR: push_val(m_mem[w.mem_addr]);
          K_MREG: begin
            if (reg_to_addr(w.reg_sel, a)) push_val(m_mem[a]);
            else r.error_code = E_ADDR;
          end
          default: begin
            push_val(m_regs[w.reg_sel]);
            if (w.arg_kind == K_RNUM) push_val(w.imm_value);
          end
        endcase
      end
      OP_POP: begin
        nip = m_ip + 17'd3;
        if (w.arg_kind != K_REG && w.arg_kind != K_MADR && w.arg_kind != K_MREG)
          nip = m_ip + 17'd2;
        else if (m_sp < 1) r.error_code = E_UND;
        else case (w.arg_kind)
          K_MADR: m_mem[w.mem_addr] = pop_val();
          K_MREG: begin
            if (reg_to_addr(w.reg_sel, a)) m_mem[a] = pop_val();
            else r.error_code = E_ADDR;
          end
          default: m_regs[w.reg_sel] = pop_val();
        endcase
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (m_sp < 2) r.error_code = E_UND;
        else begin
          tp = sx(m_stack[m_sp-1]);
          nx = sx(m_stack[m_sp-2]);
          if (w.cmd == OP_DIV && tp == 0) r.error_code = E_DZ;
          else begin
            m_sp -= 2;
            push_val(alu_q16(w.cmd, nx, tp));
          end
        end
      end
      OP_OUT: begin
        if (m_sp < 1) r.error_code = E_UND;
        else begin
          r.out_value = pop_val();
          r.out_valid = 1'b1;
        end
      end
      OP_HLT: m_halt = 1'b1;
      OP_JMP: nip = {1'b0, w.jump_target};
      OP_JB, OP_JBE, OP_JA, OP_JAE: begin
        nip = m_ip + 17'd2;
        if (m_sp < 2) r.error_code = E_UND;
        else begin
          tp = sx(pop_val());
          nx = sx(pop_val());
          case (w.cmd)
            OP_JB:   taken = nx < tp;
            OP_JBE:  taken = nx <= tp;
            OP_JA:   taken = nx > tp;
            default: taken = nx >= tp;
          endcase
          if (taken) nip = {1'b0, w.jump_target};
        end
      end
      default: ; // unknown opcode: one word, nothing done
    endcase
    m_ip = nip[15:0];
    if (m_ip >= m_len) m_halt = 1'b1;
    r.next_ip = m_ip;
    r.halted  = m_halt;
  endtask

  // --- driving --------------------------------------------------------------
  function automatic smx_instr_t mk(input logic [3:0] op, input logic [2:0] kind,
                                    input logic [31:0] imm, input logic [1:0] rs,
                                    input logic [6:0] ma, input logic [15:0] jt);
    smx_instr_t w;
    w.cmd = op; w.arg_kind = kind; w.imm_value = imm;
    w.reg_sel = rs; w.mem_addr = ma; w.jump_target = jt;
    return w;
  endfunction

  // Offers one word; valid is left high after acceptance so that the next call
  // (or a drain) makes the only assignment to it in that time step.
  task automatic send_word(input smx_instr_t w);
    smx_result_t r;
    while ($urandom_range(0, 99) < src_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_machine(w, r);
    expected_words.push_back(r);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_length(input logic [15:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_len = v;
  endtask

  // Pulls the pointer back first so a shorter program does not halt us.
  task automatic set_length(input logic [15:0] v);
    if (!m_halt && 32'(m_ip) + 10 >= 32'(v)) send_word(mk(OP_JMP, K_NUM, 0, 0, 0, 0));
    write_length(v);
  endtask

  task automatic drain_stack();
    while (m_sp > 0) send_word(mk(OP_OUT, K_NUM, $urandom, 0, 0, 0));
  endtask

  // --- tests ----------------------------------------------------------------
  task automatic test_directed();
    send_word(mk(OP_POP,  K_REG,  0, 0, 0, 0));               // underflow on pop
    send_word(mk(OP_ADD,  K_NUM,  0, 0, 0, 0));               // underflow on arith
    send_word(mk(OP_PUSH, K_NUM,  32'h7fff_ffff, 0, 0, 0));
    send_word(mk(OP_PUSH, K_NUM,  32'h0000_0001, 0, 0, 0));
    send_word(mk(OP_ADD,  K_NUM,  0, 0, 0, 0));               // saturates high
    send_word(mk(OP_PUSH, K_NUM,  32'h8000_0000, 0, 0, 0));
    send_word(mk(OP_SUB,  K_NUM,  0, 0, 0, 0));               // max - min
    send_word(mk(OP_PUSH, K_NUM,  32'h0, 0, 0, 0));
    send_word(mk(OP_DIV,  K_NUM,  0, 0, 0, 0));               // divide by zero
    send_word(mk(OP_POP,  K_REG,  0, 3, 0, 0));
    send_word(mk(OP_PUSH, K_NUM,  32'h0002_0000, 0, 0, 0));
    send_word(mk(OP_MUL,  K_NUM,  0, 0, 0, 0));               // saturating mul
    send_word(mk(OP_PUSH, K_NUM,  32'hffff_0000, 0, 0, 0));
    send_word(mk(OP_POP,  K_REG,  0, 1, 0, 0));               // r1 = -1.0
    send_word(mk(OP_PUSH, K_MREG, 0, 1, 0, 0));               // negative address
    send_word(mk(OP_PUSH, K_RNUM, 32'h0005_8000, 1, 0, 0));   // register then number
    send_word(mk(OP_POP,  K_MADR, 0, 0, 7'd127, 0));
    send_word(mk(OP_PUSH, K_MADR, 0, 0, 7'd127, 0));
    send_word(mk(OP_PUSH, K_NUM,  32'h0080_0000, 0, 0, 0));   // 128.0: past memory
    send_word(mk(OP_POP,  K_REG,  0, 2, 0, 0));
    send_word(mk(OP_POP,  K_MREG, 0, 2, 0, 0));
    send_word(mk(OP_PUSH, K_NUM,  32'hfffe_8000, 0, 0, 0));   // -1.5
    send_word(mk(OP_MUL,  K_NUM,  0, 0, 0, 0));               // negative product floors
    send_word(mk(OP_DIV,  K_NUM,  0, 0, 0, 0));
    send_word(mk(OP_JB,   K_NUM,  0, 0, 0, 16'd40));
    send_word(mk(OP_PUSH, K_NUM,  32'h0003_0000, 0, 0, 0));
    send_word(mk(OP_POP,  K_REG,  0, 0, 0, 0));
    send_word(mk(OP_POP,  K_MREG, 0, 0, 0, 0));
    send_word(mk(OP_PUSH, K_MREG, 0, 0, 0, 0));
    send_word(mk(OP_PUSH, K_NUM,  32'h0003_0000, 0, 0, 0));
    send_word(mk(OP_JAE,  K_NUM,  0, 0, 0, 16'd60));
    send_word(mk(OP_PUSH, K_REG,  0, 3, 0, 0));
    send_word(mk(OP_PUSH, K_REG,  0, 3, 0, 0));
    send_word(mk(OP_JA,   K_NUM,  0, 0, 0, 16'd90));
    send_word(mk(OP_JBE,  K_NUM,  0, 0, 0, 16'd90));          // underflow on jump
    send_word(mk(OP_PUSH, 3'd6,   0, 0, 0, 0));               // unused push mode
    send_word(mk(OP_POP,  K_NUM,  0, 0, 0, 0));               // unused pop mode
    send_word(mk(4'd14,   K_NUM,  0, 0, 0, 0));               // unknown opcode
    send_word(mk(OP_JMP,  K_NUM,  0, 0, 0, 16'd5));
    drain_stack();
  endtask

  // Fill to the top, overflow with both push sizes, then empty past the bottom.
  task automatic test_stack_limits();
    for (int i = 0; i < STACK_DEPTH; i++) send_word(mk(OP_PUSH, K_NUM, $urandom, 0, 0, 0));
    send_word(mk(OP_PUSH, K_NUM,  $urandom, 0, 0, 0));
    send_word(mk(OP_OUT,  K_NUM,  0, 0, 0, 0));
    send_word(mk(OP_PUSH, K_RNUM, $urandom, 2, 0, 0));
    drain_stack();
    send_word(mk(OP_OUT,  K_NUM,  0, 0, 0, 0));
    send_word(mk(OP_JMP,  K_NUM,  0, 0, 0, 16'd0));
  endtask

  task automatic gen_word(output smx_instr_t w);
    int sel;
    int k;
    w = {$urandom, $urandom};
    w.jump_target = 16'($urandom_range(0, m_len - 8));
    k = $urandom_range(0, 9);
    case (k)
      0: w.imm_value = 32'h7fff_ffff;
      1: w.imm_value = 32'h8000_0000;
      2: w.imm_value = 32'h0;
      3, 4, 5: w.imm_value = {16'($urandom_range(0, 140)), 16'($urandom)};
      6: w.imm_value = -{16'($urandom_range(0, 5)), 16'($urandom)};
      default: ;
    endcase
    if (32'(m_ip) + 8 >= 32'(m_len)) begin
      w.cmd = OP_JMP;
      w.jump_target = 16'($urandom_range(0, m_len / 2));
      return;
    end
    sel = $urandom_range(0, 99);
    if (sel < 30 || (m_sp < 2 && sel < 55)) begin
      w.cmd = OP_PUSH;
      w.arg_kind = 3'($urandom_range(0, 4));
    end else if (sel < 45) begin
      w.cmd = OP_POP;
      case ($urandom_range(0, 2))
        0: w.arg_kind = K_REG;
        1: w.arg_kind = K_MADR;
        default: w.arg_kind = K_MREG;
      endcase
    end else if (sel < 70) w.cmd = 4'($urandom_range(OP_ADD, OP_DIV));
    else if (sel < 80) w.cmd = OP_OUT;
    else if (sel < 88) w.cmd = 4'($urandom_range(OP_JB, OP_JAE));
    else if (sel < 92) w.cmd = OP_JMP;
    else if (w.cmd == OP_HLT) w.cmd = 4'd15; // noise, but never a halt mid-run
  endtask

  task automatic run_random(input int n, input int s_pct, input int k_pct);
    smx_instr_t w;
    src_pct = s_pct;
    snk_pct = k_pct;
    for (int i = 0; i < n; i++) begin
      gen_word(w);
      send_word(w);
    end
    src_pct = 0;
    snk_pct = 0;
  endtask

  // Halt is sticky until reset, so this runs last.
  task automatic test_halt();
    send_word(mk(OP_HLT, K_NUM, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_word({$urandom, $urandom});
    write_length(16'd0);
    for (int i = 0; i < 4; i++) send_word({$urandom, $urandom});
  endtask

  // --- result checking ------------------------------------------------------
  always @(posedge clk) begin
    smx_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_ch.data);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_ch.data.next_ip !== e.next_ip) begin
          $display("%0t: next_ip exp %h got %h", $time, e.next_ip, out_ch.data.next_ip);
          fail_count++;
        end
        if (out_ch.data.out_valid !== e.out_valid) begin
          $display("%0t: out_valid exp %b got %b", $time, e.out_valid, out_ch.data.out_valid);
          fail_count++;
        end
        if (out_ch.data.out_value !== e.out_value) begin
          $display("%0t: out_value exp %h got %h", $time, e.out_value, out_ch.data.out_value);
          fail_count++;
        end
        if (out_ch.data.halted !== e.halted) begin
          $display("%0t: halted exp %b got %b", $time, e.halted, out_ch.data.halted);
          fail_count++;
        end
        if (out_ch.data.error_code !== e.error_code) begin
          $display("%0t: error_code exp %0d got %0d", $time, e.error_code,
                   out_ch.data.error_code);
          fail_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= snk_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    fail_count   = 0;
    src_pct      = 0;
    snk_pct      = 0;
    cycles       = 0;
    m_sp = 0; m_ip = '0; m_halt = 1'b0; m_len = '0;
    foreach (m_stack[i]) m_stack[i] = '0;
    foreach (m_regs[i]) m_regs[i] = '0;
    foreach (m_mem[i]) m_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_length(16'hffff);
    test_directed();
    test_stack_limits();
    set_length(16'd2000);
    run_random(350, 0, 0);
    set_length(16'd400);
    run_random(350, 84, 0);
    set_length(16'hffff);
    run_random(350, 0, 84);
    set_length(16'd300);
    run_random(350, 12, 12);
    test_halt();

    wait_drained();
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
